/* hdl/sctp_path_congestion_window_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the path congestion window block
// Concurrent checks on the rising clock edge, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SCTP_PATH_CONGESTION_WINDOW_TOP_ASSERT_SVH
`define SCTP_PATH_CONGESTION_WINDOW_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Property that holds in the same cycle
`define SCW_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: %m");

// Antecedent in one cycle, consequent in the next
`define SCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`else

`define SCW_ASSERT(label, clk, rst, prop)
`define SCW_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/scw_pkg.sv */
// ----------------------------------------------------------------------------
// scw_pkg
// Types and constants shared by the path congestion window block.
// ----------------------------------------------------------------------------
package scw_pkg;

  // Floor of the initial and idle window, in bytes
  localparam logic [31:0] MIN_INIT_WINDOW = 32'd4380;

  // Configuration register indexes
  localparam logic [1:0] REG_PEER_WINDOW = 2'd0;
  localparam logic [1:0] REG_MAX_BURST   = 2'd1;
  localparam logic [1:0] REG_FR_ENABLE   = 2'd2;

  typedef enum logic [2:0] {
    OP_INIT        = 3'd0,
    OP_ACKED       = 3'd1,
    OP_SACK_RTX    = 3'd2,
    OP_FR_EXIT     = 3'd3,
    OP_RTX_TIMEOUT = 3'd4,
    OP_MAX_BURST   = 3'd5,
    OP_IDLE        = 3'd6
  } opcode_t;

  // One path entry of the table
  typedef struct packed {
    logic [31:0] cwnd;
    logic [31:0] ssth;
    logic [31:0] pba;
    logic        fr;
    logic [31:0] ex;
  } entry_t;

  // Captured request, with the terms that need no table state worked out
  typedef struct packed {
    opcode_t     opcode;
    logic        in_range;
    logic [15:0] mtu;
    logic [31:0] acked;
    logic        adv;
    logic [31:0] out_before;
    logic [32:0] before_mtu;
    logic        now_zero;
    logic        rtx;
    logic [31:0] hi_tsn;
    logic [31:0] last;
    logic [31:0] init_win;
    logic [31:0] four_mtu;
    logic [31:0] min_inc;
    logic [32:0] burst_lim;
    logic [31:0] peer_win;
    logic        fr_en;
  } ev_t;

endpackage

/* hdl/scw_in_if.sv */
// ----------------------------------------------------------------------------
// scw_in_if
// Request channel: one congestion event for one path.
// ----------------------------------------------------------------------------
interface scw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [3:0]  path_index;
  logic [15:0] path_mtu;
  logic [31:0] acked_bytes;
  logic        cum_ack_advanced;
  logic [31:0] outstanding_before;
  logic [31:0] outstanding_now;
  logic        needs_retransmit;
  logic [31:0] highest_outstanding_tsn;
  logic [31:0] last_tsn_ack;

  modport source (
    output valid, opcode, path_index, path_mtu, acked_bytes, cum_ack_advanced,
           outstanding_before, outstanding_now, needs_retransmit,
           highest_outstanding_tsn, last_tsn_ack,
    input  ready
  );

  modport sink (
    input  valid, opcode, path_index, path_mtu, acked_bytes, cum_ack_advanced,
           outstanding_before, outstanding_now, needs_retransmit,
           highest_outstanding_tsn, last_tsn_ack,
    output ready
  );
endinterface

/* hdl/scw_out_if.sv */
// ----------------------------------------------------------------------------
// scw_out_if
// Result channel: the path entry after the event.
// ----------------------------------------------------------------------------
interface scw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] window_out;
  logic [31:0] threshold_out;
  logic [31:0] partial_acked_out;
  logic        in_fast_recovery;
  logic [31:0] recovery_exit_out;
  logic        window_changed;

  modport source (
    output valid, window_out, threshold_out, partial_acked_out,
           in_fast_recovery, recovery_exit_out, window_changed,
    input  ready
  );

  modport sink (
    input  valid, window_out, threshold_out, partial_acked_out,
           in_fast_recovery, recovery_exit_out, window_changed,
    output ready
  );
endinterface

/* hdl/sctp_path_congestion_window_top.sv */
// ----------------------------------------------------------------------------
// sctp_path_congestion_window_top
// Per-path SCTP congestion window engine over a path table held in RAM.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     carries
//  evt      in   valid/ready   opcode, path and SACK/timer figures
//  res      out  valid/ready   entry after the event, window change flag
//  cfg      in   cfg_we        peer window, max burst, fast recovery enable
//
//  The table is read in the accept cycle (ST_IDLE); the entry is updated
//  and written back in ST_EXEC, which also loads the output register.
//  Because of the RAM read-modify-write, one request is in flight.
//  A new request is taken while a result waits; the update cycle holds until
//  the output register is free. Reset clears the entry valid bits and sets the
//  configuration registers to their defaults at once; an entry never written reads as zero.
// ----------------------------------------------------------------------------
`include "sctp_path_congestion_window_top_assert.svh"

module sctp_path_congestion_window_top import scw_pkg::*; #(
  parameter int MAX_PATHS = 16
) (
  input  logic        clk,
  input  logic        rst,
  scw_in_if.sink      evt,
  scw_out_if.source   res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [31:0] peer_win;
  logic [7:0]  max_burst;
  logic        fr_enable;

  logic            accept;
  logic            advance;
  logic [AW+3:0]   path_wide;
  logic [AW-1:0]   evt_addr;
  logic            evt_in_range;
  logic [23:0]     burst_bytes;
  logic [31:0]     mtu_two;
  ev_t             ev_capt;
  ev_t             ev;
  logic [AW-1:0]   ev_addr;
  logic            entry_hit;
  logic [MAX_PATHS-1:0] entry_valid;
  logic [$bits(entry_t)-1:0] ram_rdata;
  logic            ram_we;
  entry_t          cur;
  entry_t          nxt;
  logic            changed;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      peer_win  <= 32'd65535;
      max_burst <= 8'd4;
      fr_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PEER_WINDOW: peer_win  <= cfg_data;
        REG_MAX_BURST:   max_burst <= cfg_data[7:0];
        REG_FR_ENABLE:   fr_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign evt.ready = (state == ST_IDLE);
  assign accept    = evt.valid && evt.ready;
  assign advance   = (state == ST_EXEC) && (!res.valid || res.ready);

  // Table address of the request
  assign path_wide    = {{AW{1'b0}}, evt.path_index};
  assign evt_addr     = path_wide[AW-1:0];
  assign evt_in_range = (32'(evt.path_index) < MAX_PATHS);

  // Terms that need no table state, formed in the accept cycle
  assign burst_bytes = {16'b0, max_burst} * {8'b0, evt.path_mtu};
  assign mtu_two     = {15'b0, evt.path_mtu, 1'b0};

  always_comb begin
    ev_capt.opcode     = opcode_t'(evt.opcode);
    ev_capt.in_range   = evt_in_range;
    ev_capt.mtu        = evt.path_mtu;
    ev_capt.acked      = evt.acked_bytes;
    ev_capt.adv        = evt.cum_ack_advanced;
    ev_capt.out_before = evt.outstanding_before;
    ev_capt.before_mtu = {1'b0, evt.outstanding_before} + {17'b0, evt.path_mtu};
    ev_capt.now_zero   = (evt.outstanding_now == '0);
    ev_capt.rtx        = evt.needs_retransmit;
    ev_capt.hi_tsn     = evt.highest_outstanding_tsn;
    ev_capt.last       = evt.last_tsn_ack;
    ev_capt.init_win   = (mtu_two > MIN_INIT_WINDOW) ? mtu_two : MIN_INIT_WINDOW;
    ev_capt.four_mtu   = {14'b0, evt.path_mtu, 2'b00};
    ev_capt.min_inc    = ({16'b0, evt.path_mtu} < evt.acked_bytes) ?
                         {16'b0, evt.path_mtu} : evt.acked_bytes;
    ev_capt.burst_lim  = {1'b0, evt.outstanding_now} + {9'b0, burst_bytes};
    ev_capt.peer_win   = peer_win;
    ev_capt.fr_en      = fr_enable;
  end

  // Request register
  always_ff @(posedge clk) begin
    if (accept) begin
      ev        <= ev_capt;
      ev_addr   <= evt_addr;
      entry_hit <= evt_in_range && entry_valid[evt_addr];
    end
  end

  // Path table
  scw_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_PATHS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ev_addr),
    .wdata (nxt),
    .re    (accept),
    .raddr (evt_addr),
    .rdata (ram_rdata)
  );

  assign cur    = entry_hit ? entry_t'(ram_rdata) : '0;
  assign ram_we = advance && ev.in_range;

  // Entry valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[ev_addr] <= 1'b1;
    end
  end

  scw_update u_update (
    .ev      (ev),
    .cur     (cur),
    .nxt     (nxt),
    .changed (changed)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept)  state_next = ST_EXEC;
      ST_EXEC: if (advance) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (ev.in_range) begin
        res.window_out        <= nxt.cwnd;
        res.threshold_out     <= nxt.ssth;
        res.partial_acked_out <= nxt.pba;
        res.in_fast_recovery  <= nxt.fr;
        res.recovery_exit_out <= nxt.fr ? nxt.ex : '0;
        res.window_changed    <= changed;
      end else begin
        res.window_out        <= '0;
        res.threshold_out     <= '0;
        res.partial_acked_out <= '0;
        res.in_fast_recovery  <= 1'b0;
        res.recovery_exit_out <= '0;
        res.window_changed    <= 1'b0;
      end
    end
  end

  // Checks
  `SCW_ASSERT_NEXT(a_accept_to_exec, clk, rst, accept, state == ST_EXEC)
  `SCW_ASSERT(a_write_in_range, clk, rst, !ram_we || (ev.in_range && state == ST_EXEC))
  `SCW_ASSERT(a_no_accept_in_exec, clk, rst, !(state == ST_EXEC) || !evt.ready)
  `SCW_ASSERT_NEXT(a_result_from_exec, clk, rst, !res.valid && !advance, !res.valid)
  `SCW_ASSERT_NEXT(a_stall_holds, clk, rst, state == ST_EXEC && res.valid && !res.ready,
                   state == ST_EXEC)

endmodule

/* hdl/scw_ram.sv */
// ----------------------------------------------------------------------------
// scw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/scw_update.sv */
// ----------------------------------------------------------------------------
// scw_update
// Next value of one path entry for one event (RFC 4960 section 7.2 rules).
// ----------------------------------------------------------------------------
module scw_update import scw_pkg::*; (
  input  ev_t    ev,
  input  entry_t cur,
  output entry_t nxt,
  output logic   changed
);

  // Saturating 32-bit increment
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  logic [31:0] half_cwnd;
  logic [31:0] reduced;
  logic [31:0] pba_sum;
  logic [31:0] cwnd_inc;
  logic [31:0] exit_diff;

  // Shared terms
  assign half_cwnd = {1'b0, cur.cwnd[31:1]};
  assign reduced   = (half_cwnd > ev.four_mtu) ? half_cwnd : ev.four_mtu;
  assign pba_sum   = sat_add(cur.pba, ev.acked);
  assign cwnd_inc  = sat_add(cur.cwnd, {16'b0, ev.mtu});
  assign exit_diff = ev.last - cur.ex;

  // Opcode decode
  always_comb begin
    nxt = cur;
    case (ev.opcode)
      OP_INIT: begin
        nxt.cwnd = ev.init_win;
        nxt.ssth = ev.peer_win;
      end
      OP_ACKED: begin
        if (!cur.fr) begin
          if (cur.cwnd <= cur.ssth) begin
            // slow start
            nxt.pba = '0;
            if (ev.adv &&
                (ev.out_before >= cur.cwnd || ev.before_mtu > {1'b0, cur.cwnd})) begin
              nxt.cwnd = sat_add(cur.cwnd, ev.min_inc);
            end
          end else begin
            // congestion avoidance
            nxt.pba = pba_sum;
            if (pba_sum >= cur.cwnd && ev.adv && ev.out_before >= cur.cwnd) begin
              nxt.cwnd = cwnd_inc;
              nxt.pba  = (cwnd_inc < pba_sum) ? (pba_sum - cwnd_inc) : '0;
            end
          end
          if (ev.now_zero) begin
            nxt.pba = '0;
          end
        end
      end
      OP_SACK_RTX: begin
        if (!cur.fr && ev.rtx) begin
          nxt.ssth = reduced;
          nxt.cwnd = reduced;
          nxt.pba  = '0;
          if (ev.fr_en) begin
            nxt.fr = 1'b1;
            nxt.ex = ev.hi_tsn;
          end
        end
      end
      OP_FR_EXIT: begin
        // serial compare: last at or beyond exit point
        if (cur.fr && !exit_diff[31]) begin
          nxt.fr = 1'b0;
          nxt.ex = '0;
        end
      end
      OP_RTX_TIMEOUT: begin
        nxt.ssth = reduced;
        nxt.cwnd = {16'b0, ev.mtu};
        nxt.pba  = '0;
        nxt.fr   = 1'b0;
        nxt.ex   = '0;
      end
      OP_MAX_BURST: begin
        if ({1'b0, cur.cwnd} > ev.burst_lim) begin
          nxt.cwnd = ev.burst_lim[31:0];
        end
      end
      OP_IDLE: begin
        nxt.cwnd = ev.init_win;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  assign changed = (nxt.cwnd != cur.cwnd);

endmodule
